### src/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### src/vbap_pkg.sv
// ----------------------------------------------------------------------------
// vbap_pkg
// Shared types and constants of the 2-D amplitude panner with gain ramps.
// ----------------------------------------------------------------------------
package vbap_pkg;

  localparam int MAX_SPEAKERS = 16;
  localparam int CH_W         = 4;
  localparam int ITER_W       = 6;

  localparam logic [ITER_W-1:0] SQRT_STEPS = 6'd32;
  localparam logic [ITER_W-1:0] DIV_STEPS  = 6'd30;
  localparam logic [ITER_W-1:0] MUL_LAST   = 6'd3;
  localparam logic [ITER_W-1:0] SQ_LAST    = 6'd1;

  localparam logic [0:0] REG_SPEAKER_COUNT = 1'b0;
  localparam logic [0:0] REG_RAMP_STEP     = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_DIR    = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_CHK,
    S_NORM,
    S_SQ,
    S_SQRT,
    S_DIV1,
    S_DIV2,
    S_WRT,
    S_SD,
    S_SM,
    S_SW,
    S_SO
  } ctrl_state_t;

  typedef struct packed {
    logic            load_entry;
    logic            start_dir;
    logic            start_smp;
    logic            fetch;
    logic            mul_en;
    logic [1:0]      mul_sel;
    logic            clr_gain;
    logic            norm;
    logic            sq_en;
    logic            sq_sel;
    logic            sqrt_init;
    logic            sqrt_step;
    logic            div_init;
    logic            div_step;
    logic            div_sel;
    logic            wr_tgt;
    logic            slope_d;
    logic            slope_m;
    logic            samp_w;
    logic            out_load;
    logic [CH_W-1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic norm_done;
    logic out_free;
    logic last_k;
  } dp_sts_t;

endpackage

### src/vbap_2d_panner_gain_ramp.sv
// ----------------------------------------------------------------------------
// vbap_2d_panner_gain_ramp
// Two-dimensional amplitude panner with per-speaker linear gain ramps.
// ----------------------------------------------------------------------------
// One item at a time. A load beat is taken in the idle state alone. A direction
// beat then visits each active pair: a fetch and four products, after which a
// pair with a negative gain is skipped, a zero direction writes zero gains, and
// any other pair is normalized, squared, rooted and divided twice, one shift,
// root bit or quotient bit per cycle, before its gains are written; then each
// speaker's slope is set by a difference step and a product step. A sample beat
// does per speaker a weight update, then the 32x24 product into the output
// register, which waits while the sink stalls.
// The next beat is taken once the last result sits in the output register.
module vbap_2d_panner_gain_ramp import vbap_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [0:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [3:0]         entry_index,
  input  logic [3:0]         first_channel,
  input  logic [3:0]         second_channel,
  input  logic signed [23:0] m11,
  input  logic signed [23:0] m12,
  input  logic signed [23:0] m21,
  input  logic signed [23:0] m22,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [23:0] audio_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         channel,
  output logic signed [23:0] speaker_sample,
  output logic               last_channel
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  vbap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  vbap_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wen        (cfg_wen),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .entry_index    (entry_index),
    .first_channel  (first_channel),
    .second_channel (second_channel),
    .m11            (m11),
    .m12            (m12),
    .m21            (m21),
    .m22            (m22),
    .dir_x          (dir_x),
    .dir_y          (dir_y),
    .audio_in       (audio_in),
    .channel        (channel),
    .speaker_sample (speaker_sample),
    .last_channel   (last_channel),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

endmodule

### src/vbap_ctrl.sv
// ----------------------------------------------------------------------------
// vbap_ctrl
// Sequencer: walks pairs and speakers and steps the shared arithmetic units.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vbap_ctrl import vbap_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  ctrl_state_t       state, state_next;
  logic [CH_W-1:0]   k, k_next;
  logic [ITER_W-1:0] iter, iter_next;
  action_t           act;

  assign act = action_t'(action);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      iter  <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    iter_next  = iter;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (act)
            ACT_DIR: begin
              state_next = S_FETCH;
              k_next     = '0;
            end
            ACT_SAMPLE: begin
              state_next = S_SW;
              k_next     = '0;
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        state_next = S_MUL;
        iter_next  = '0;
      end
      S_MUL: begin
        iter_next = iter + 6'd1;
        if (iter == MUL_LAST) state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.neg) begin
          if (sts.last_k) begin
            state_next = S_SD;
            k_next     = '0;
          end else begin
            state_next = S_FETCH;
            k_next     = k + 4'd1;
          end
        end else if (sts.zero) begin
          state_next = S_WRT;
        end else begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.norm_done) begin
          state_next = S_SQ;
          iter_next  = '0;
        end
      end
      S_SQ: begin
        iter_next = iter + 6'd1;
        if (iter == SQ_LAST) begin
          state_next = S_SQRT;
          iter_next  = '0;
        end
      end
      S_SQRT: begin
        iter_next = iter + 6'd1;
        if (iter == SQRT_STEPS) begin
          state_next = S_DIV1;
          iter_next  = '0;
        end
      end
      S_DIV1: begin
        iter_next = iter + 6'd1;
        if (iter == DIV_STEPS) begin
          state_next = S_DIV2;
          iter_next  = '0;
        end
      end
      S_DIV2: begin
        iter_next = iter + 6'd1;
        if (iter == DIV_STEPS) begin
          state_next = S_WRT;
          iter_next  = '0;
        end
      end
      S_WRT: begin
        if (sts.last_k) begin
          state_next = S_SD;
          k_next     = '0;
        end else begin
          state_next = S_FETCH;
          k_next     = k + 4'd1;
        end
      end
      S_SD: state_next = S_SM;
      S_SM: begin
        if (sts.last_k) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SD;
          k_next     = k + 4'd1;
        end
      end
      S_SW: state_next = S_SO;
      S_SO: begin
        if (sts.out_free) begin
          if (sts.last_k) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_SW;
            k_next     = k + 4'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.k       = k;
    cmd.mul_sel = iter[1:0];
    cmd.sq_sel  = iter[0];
    cmd.div_sel = (state == S_DIV2);
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_entry = in_valid && (act == ACT_LOAD);
        cmd.start_dir  = in_valid && (act == ACT_DIR);
        cmd.start_smp  = in_valid && (act == ACT_SAMPLE);
      end
      S_FETCH: cmd.fetch = 1'b1;
      S_MUL:   cmd.mul_en = 1'b1;
      S_CHK:   cmd.clr_gain = !sts.neg && sts.zero;
      S_NORM:  cmd.norm = !sts.norm_done;
      S_SQ:    cmd.sq_en = 1'b1;
      S_SQRT: begin
        cmd.sqrt_init = (iter == '0);
        cmd.sqrt_step = (iter != '0);
      end
      S_DIV1, S_DIV2: begin
        cmd.div_init = (iter == '0);
        cmd.div_step = (iter != '0);
      end
      S_WRT:   cmd.wr_tgt = 1'b1;
      S_SD:    cmd.slope_d = 1'b1;
      S_SM:    cmd.slope_m = 1'b1;
      S_SW:    cmd.samp_w = 1'b1;
      S_SO:    cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  `ASSERT_IMPLIES(a_out_load_free, clk, rst, cmd.out_load, sts.out_free)
  `ASSERT_IMPLIES(a_sqrt_nonneg, clk, rst, state == S_SQRT, !sts.neg && !sts.zero)
  `ASSERT_NEXT(a_dir_fetch, clk, rst, cmd.start_dir, state == S_FETCH && k == '0)

endmodule

### src/vbap_dp.sv
// ----------------------------------------------------------------------------
// vbap_dp
// Datapath: pair tables, shared multiplier, norm/sqrt/divide units, gain ramps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vbap_dp import vbap_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               cfg_wen,
  input  logic [0:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic [3:0]         entry_index,
  input  logic [3:0]         first_channel,
  input  logic [3:0]         second_channel,
  input  logic signed [23:0] m11,
  input  logic signed [23:0] m12,
  input  logic signed [23:0] m21,
  input  logic signed [23:0] m22,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [23:0] audio_in,
  output logic [3:0]         channel,
  output logic signed [23:0] speaker_sample,
  output logic               last_channel,
  output logic               out_valid,
  input  logic               out_ready
);

  function automatic logic [31:0] sat32(input logic [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    else if (v[33]) return 32'h8000_0000;
    else return 32'h7FFF_FFFF;
  endfunction

  function automatic logic [23:0] sat24(input logic [26:0] v);
    if (v[26:23] == 4'b0000 || v[26:23] == 4'b1111) return v[23:0];
    else if (v[26]) return 24'h80_0000;
    else return 24'h7F_FFFF;
  endfunction

  logic [4:0]  spk_count;
  logic [15:0] ramp;
  logic [4:0]  cnt;

  logic [7:0]  pch [MAX_SPEAKERS];
  logic [47:0] pmt [MAX_SPEAKERS];
  logic [47:0] pmb [MAX_SPEAKERS];
  logic [31:0] weight [MAX_SPEAKERS];
  logic [31:0] slope  [MAX_SPEAKERS];
  logic [29:0] tgt    [MAX_SPEAKERS];

  logic signed [15:0] x, y;
  logic signed [23:0] smp;
  logic [3:0]         e_c1, e_c2;
  logic signed [23:0] a11, a12, a21, a22;

  logic signed [15:0] mop_a;
  logic signed [23:0] mop_b;
  logic signed [39:0] mprod;
  logic signed [40:0] g1, g2, mx;

  logic [30:0] sq_op;
  logic [61:0] sq_p;
  logic [62:0] acc;

  logic [62:0] sx, sr, sb, s_sum;
  logic [31:0] n;

  logic [30:0] dvd_u;
  logic [31:0] rem;
  logic [29:0] dsh;
  logic [32:0] dt;
  logic        dge;
  logic [29:0] gq1, gq2;

  logic signed [32:0] d_reg;
  logic signed [49:0] sprod;
  logic [31:0]        w_reg;
  logic [32:0]        w_sum;
  logic signed [55:0] oprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      spk_count <= 5'd2;
      ramp      <= 16'd64;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_SPEAKER_COUNT: spk_count <= cfg_wdata[4:0];
        REG_RAMP_STEP:     ramp      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (spk_count < 5'd2) cnt = 5'd2;
    else if (spk_count > 5'd16) cnt = 5'd16;
    else cnt = spk_count;
  end

  // Shared 16x24 multiplier: g1 = x*m11 + y*m21, g2 = x*m12 + y*m22.
  always_comb begin
    mop_a = cmd.mul_sel[0] ? y : x;
    case (cmd.mul_sel)
      2'd0:    mop_b = a11;
      2'd1:    mop_b = a21;
      2'd2:    mop_b = a12;
      default: mop_b = a22;
    endcase
  end
  assign mprod = mop_a * mop_b;

  assign mx    = (g1 > g2) ? g1 : g2;
  assign sq_op = cmd.sq_sel ? g2[30:0] : g1[30:0];
  assign sq_p  = sq_op * sq_op;
  assign s_sum = sr + sb;
  assign n     = sr[31:0];
  assign dvd_u = cmd.div_sel ? g2[30:0] : g1[30:0];
  assign dt    = {rem, dsh[29]};
  assign dge   = dt >= {1'b0, n};
  assign sprod = d_reg * $signed({1'b0, ramp});
  assign w_sum = {weight[cmd.k][31], weight[cmd.k]} + {slope[cmd.k][31], slope[cmd.k]};
  assign oprod = $signed(w_reg) * smp;

  always_ff @(posedge clk) begin
    if (cmd.load_entry) begin
      pch[entry_index] <= {second_channel, first_channel};
      pmt[entry_index] <= {m12, m11};
      pmb[entry_index] <= {m22, m21};
    end
    if (cmd.start_dir) begin
      x <= dir_x;
      y <= dir_y;
      for (int i = 0; i < MAX_SPEAKERS; i++) tgt[i] <= '0;
    end
    if (cmd.start_smp) smp <= audio_in;
    if (cmd.fetch) begin
      e_c1 <= pch[cmd.k][3:0];
      e_c2 <= pch[cmd.k][7:4];
      a11  <= pmt[cmd.k][23:0];
      a12  <= pmt[cmd.k][47:24];
      a21  <= pmb[cmd.k][23:0];
      a22  <= pmb[cmd.k][47:24];
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        2'd0:    g1 <= {mprod[39], mprod};
        2'd1:    g1 <= g1 + {mprod[39], mprod};
        2'd2:    g2 <= {mprod[39], mprod};
        default: g2 <= g2 + {mprod[39], mprod};
      endcase
    end
    if (cmd.norm) begin
      if (mx[40:31] != '0) begin
        g1 <= g1 >>> 1;
        g2 <= g2 >>> 1;
      end else begin
        g1 <= g1 <<< 1;
        g2 <= g2 <<< 1;
      end
    end
    if (cmd.sq_en) begin
      if (cmd.sq_sel) acc <= acc + {1'b0, sq_p};
      else acc <= {1'b0, sq_p};
    end
    if (cmd.sqrt_init) begin
      sx <= acc;
      sr <= '0;
      sb <= {1'b1, 62'b0};
    end else if (cmd.sqrt_step) begin
      if (sx >= s_sum) begin
        sx <= sx - s_sum;
        sr <= (sr >> 1) + sb;
      end else begin
        sr <= sr >> 1;
      end
      sb <= sb >> 2;
    end
    if (cmd.div_init) begin
      rem <= {2'b00, dvd_u[30:1]};
      dsh <= {dvd_u[0], 29'b0};
    end else if (cmd.div_step) begin
      rem <= dge ? 32'(dt - {1'b0, n}) : dt[31:0];
      dsh <= dsh << 1;
      if (cmd.div_sel) gq2 <= {gq2[28:0], dge};
      else gq1 <= {gq1[28:0], dge};
    end
    if (cmd.clr_gain) begin
      gq1 <= '0;
      gq2 <= '0;
    end
    if (cmd.wr_tgt) begin
      // both vertices on one channel: the second vertex wins
      if ({1'b0, e_c1} < cnt && e_c1 != e_c2) tgt[e_c1] <= gq1;
      if ({1'b0, e_c2} < cnt) tgt[e_c2] <= gq2;
    end
    if (cmd.slope_d)
      d_reg <= $signed({3'b000, tgt[cmd.k]}) - $signed({weight[cmd.k][31], weight[cmd.k]});
    if (cmd.samp_w) w_reg <= sat32({w_sum[32], w_sum});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SPEAKERS; i++) begin
        weight[i] <= '0;
        slope[i]  <= '0;
      end
    end else begin
      if (cmd.slope_m) slope[cmd.k] <= sat32(sprod[49:16]);
      if (cmd.samp_w) weight[cmd.k] <= sat32({w_sum[32], w_sum});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      channel        <= cmd.k;
      speaker_sample <= sat24(oprod[55:29]);
      last_channel   <= sts.last_k;
    end
  end

  assign sts.neg       = g1[40] | g2[40];
  assign sts.zero      = (g1 == '0) && (g2 == '0);
  assign sts.norm_done = (mx[40:31] == '0) && mx[30];
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.last_k    = ({1'b0, cmd.k} == cnt - 5'd1);

  `ASSERT_IMPLIES(a_sq_normed, clk, rst, cmd.sq_en, g1[40:31] == '0 && g2[40:31] == '0)
  `ASSERT_IMPLIES(a_div_rem, clk, rst, cmd.div_step, rem < n)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Panner with gain ramps: a directed table, then random beats in several
// register settings, every sample result checked against a local model.
// ----------------------------------------------------------------------------
module testbench;
  import vbap_pkg::*;

  typedef struct {
    logic [1:0]         act;
    logic [3:0]         idx;
    logic [3:0]         c1;
    logic [3:0]         c2;
    logic signed [23:0] a11;
    logic signed [23:0] a12;
    logic signed [23:0] a21;
    logic signed [23:0] a22;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [23:0] smp;
    bit                 known_zero;
  } beat_t;

  typedef struct {
    logic [3:0]         ch;
    logic signed [23:0] val;
    logic               last;
  } spk_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [0:0]         cfg_addr = '0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         action = '0;
  logic [3:0]         entry_index = '0;
  logic [3:0]         first_channel = '0;
  logic [3:0]         second_channel = '0;
  logic signed [23:0] m11 = '0, m12 = '0, m21 = '0, m22 = '0;
  logic signed [15:0] dir_x = '0, dir_y = '0;
  logic signed [23:0] audio_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         channel;
  logic signed [23:0] speaker_sample;
  logic               last_channel;

  vbap_2d_panner_gain_ramp u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [3:0]         pm_ch1 [MAX_SPEAKERS];
  logic [3:0]         pm_ch2 [MAX_SPEAKERS];
  longint             pm_a11 [MAX_SPEAKERS], pm_a12 [MAX_SPEAKERS];
  longint             pm_a21 [MAX_SPEAKERS], pm_a22 [MAX_SPEAKERS];
  bit                 pm_loaded [MAX_SPEAKERS];
  longint             weight [MAX_SPEAKERS];
  longint             slope [MAX_SPEAKERS];
  int unsigned        spk_count_reg = 2;
  longint             ramp_reg = 64;

  spk_out_t           speaker_q[$];
  int                 fails = 0;
  longint             cycles = 0;
  bit                 burst_in = 0, burst_out = 0;
  int                 stall_left = 0;

  function automatic int unsigned active_spk();
    if (spk_count_reg < 2) return 2;
    if (spk_count_reg > 16) return 16;
    return spk_count_reg;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // returns 1 when both gains are non-negative; gains in unsigned Q1.29
  function automatic bit pair_gains(int e, longint x, longint y,
                                    output longint t1, output longint t2);
    longint g1, g2;
    longint unsigned u1, u2, mx, n;
    g1 = x * pm_a11[e] + y * pm_a21[e];
    g2 = x * pm_a12[e] + y * pm_a22[e];
    t1 = 0;
    t2 = 0;
    if (g1 < 0 || g2 < 0) return 0;
    u1 = g1;
    u2 = g2;
    mx = u1 > u2 ? u1 : u2;
    if (mx == 0) return 1;
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1; u1 = u1 >> 1; u2 = u2 >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1; u1 = u1 << 1; u2 = u2 << 1;
    end
    n = int_sqrt(u1 * u1 + u2 * u2);
    t1 = (u1 << 29) / n;
    t2 = (u2 << 29) / n;
    return 1;
  endfunction

  task automatic predict_beat(beat_t b);
    int unsigned cnt, k;
    longint tgt [MAX_SPEAKERS];
    longint t1, t2, w;
    spk_out_t o;
    cnt = active_spk();
    case (action_t'(b.act))
      ACT_LOAD: begin
        pm_ch1[b.idx] = b.c1;
        pm_ch2[b.idx] = b.c2;
        pm_a11[b.idx] = longint'(b.a11);
        pm_a12[b.idx] = longint'(b.a12);
        pm_a21[b.idx] = longint'(b.a21);
        pm_a22[b.idx] = longint'(b.a22);
        pm_loaded[b.idx] = 1;
      end
      ACT_DIR: begin
        for (k = 0; k < MAX_SPEAKERS; k++) tgt[k] = 0;
        for (k = 0; k < cnt; k++) begin
          if (pair_gains(int'(k), longint'(b.dx), longint'(b.dy), t1, t2)) begin
            if (pm_ch1[k] < cnt) tgt[pm_ch1[k]] = t1;
            if (pm_ch2[k] < cnt) tgt[pm_ch2[k]] = t2;
          end
        end
        for (k = 0; k < cnt; k++)
          slope[k] = sat(((tgt[k] - weight[k]) * ramp_reg) >>> 16,
                         -(64'sd1 << 31), (64'sd1 << 31) - 1);
      end
      ACT_SAMPLE: begin
        for (k = 0; k < cnt; k++) begin
          w = sat(weight[k] + slope[k], -(64'sd1 << 31), (64'sd1 << 31) - 1);
          weight[k] = w;
          o.ch = 4'(k);
          o.val = b.known_zero ? 24'sd0 :
                  24'(sat((w * longint'(b.smp)) >>> 29, -8388608, 8388607));
          o.last = (k + 1 == cnt);
          speaker_q.insert(speaker_q.size(), o);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(beat_t b);
    int gap;
    gap = burst_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action         <= b.act;
    entry_index    <= b.idx;
    first_channel  <= b.c1;
    second_channel <= b.c2;
    m11 <= b.a11; m12 <= b.a12; m21 <= b.a21; m22 <= b.a22;
    dir_x <= b.dx; dir_y <= b.dy;
    audio_in <= b.smp;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(b);
  endtask

  task automatic cfg_write(logic [0:0] idx, logic [15:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    if (idx == REG_SPEAKER_COUNT) spk_count_reg = 32'(val[4:0]);
    else ramp_reg = 64'(val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (speaker_q.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  function automatic beat_t random_beat();
    beat_t b;
    int unsigned cnt, r, k;
    cnt = active_spk();
    b.act = ACT_SAMPLE;
    b.idx = 4'($urandom); b.c1 = 4'($urandom); b.c2 = 4'($urandom);
    b.a11 = 24'($urandom); b.a12 = 24'($urandom);
    b.a21 = 24'($urandom); b.a22 = 24'($urandom);
    b.dx = 16'($urandom); b.dy = 16'($urandom); b.smp = 24'($urandom);
    b.known_zero = 0;
    r = $urandom_range(0, 99);
    if (r < 5) b.act = ACT_NONE;
    else if (r < 30) b.act = ACT_LOAD;
    else if (r < 50) b.act = ACT_DIR;
    if (b.act == ACT_LOAD && $urandom_range(0, 3) != 0) begin
      // plausible pair: small positive-leaning matrix, channels in use
      b.idx = 4'($urandom_range(0, cnt - 1));
      b.c1 = 4'($urandom_range(0, cnt - 1));
      b.c2 = 4'($urandom_range(0, cnt - 1));
      b.a11 = 24'($urandom_range(0, 200000));
      b.a22 = 24'($urandom_range(0, 200000));
      b.a12 = 24'($signed($urandom_range(0, 100000)) - 50000);
      b.a21 = 24'($signed($urandom_range(0, 100000)) - 50000);
    end
    if (b.act == ACT_DIR) begin
      for (k = 0; k < cnt; k++) begin
        if (!pm_loaded[k] && b.act == ACT_DIR) begin
          b.act = ACT_LOAD;
          b.idx = 4'(k);
        end
      end
    end
    return b;
  endfunction

  // result side: check each beat, then, unless in output burst mode, stall at random
  always @(posedge clk) begin
    spk_out_t e;
    int       st;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (speaker_q.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          e = speaker_q.pop_front();
          if (channel !== e.ch) begin
            $error("channel: expected %0d, got %0d", e.ch, channel);
            fails++;
          end
          if (speaker_sample !== e.val) begin
            $error("speaker_sample: expected %0d, got %0d", e.val, speaker_sample);
            fails++;
          end
          if (last_channel !== e.last) begin
            $error("last_channel: expected %0d, got %0d", e.last, last_channel);
            fails++;
          end
        end
        st = burst_out ? 0 : $urandom_range(0, 12);
        if (st == 0) begin
          out_ready <= 1'b1;
        end else begin
          stall_left <= st;
          out_ready <= 1'b0;
        end
      end else if (!out_ready) begin
        if (stall_left <= 1) out_ready <= 1'b1;
        else stall_left <= stall_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  beat_t dir_tab [18];
  int unsigned sc_tab [8] = '{16, 2, 0, 31, 1, 9, 16, 5};
  int unsigned rs_tab [8] = '{65535, 0, 64, 1, 65535, 32768, 4096, 12345};

  initial begin
    int i, p, n;
    for (i = 0; i < MAX_SPEAKERS; i++) begin
      weight[i] = 0; slope[i] = 0; pm_loaded[i] = 0;
      pm_ch1[i] = 0; pm_ch2[i] = 0;
      pm_a11[i] = 0; pm_a12[i] = 0; pm_a21[i] = 0; pm_a22[i] = 0;
    end
    //          act         idx c1 c2 m11       m12       m21       m22      dx      dy     smp
    dir_tab[0]  = '{ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'sd8388607, 1};
    dir_tab[1]  = '{ACT_SAMPLE, 15, 15, 15, -1, -1, -1, -1, -1, -1, -24'sd8388608, 1};
    dir_tab[2]  = '{ACT_NONE, 15, 15, 15, -1, -1, -1, -1, -1, -1, -1, 0};
    dir_tab[3]  = '{ACT_LOAD, 0, 0, 1, 65536, 0, 0, 65536, 0, 0, 0, 0};
    dir_tab[4]  = '{ACT_LOAD, 1, 1, 0, 24'sd8388607, -24'sd8388608,
                    -24'sd8388608, 24'sd8388607, 0, 0, 0, 0};
    dir_tab[5]  = '{ACT_LOAD, 15, 15, 15, -24'sd8388608, -24'sd8388608,
                    24'sd8388607, 24'sd8388607, 0, 0, 0, 0};
    dir_tab[6]  = '{ACT_DIR, 0, 0, 0, 0, 0, 0, 0, 16'sd32767, 0, 0, 0};
    dir_tab[7]  = '{ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'sd8388607, 0};
    dir_tab[8]  = '{ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, -24'sd8388608, 0};
    dir_tab[9]  = '{ACT_DIR, 0, 0, 0, 0, 0, 0, 0, 16'sd23170, 16'sd23170, 0, 0};
    dir_tab[10] = '{ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'sd1000000, 0};
    dir_tab[11] = '{ACT_DIR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_tab[12] = '{ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, -24'sd1, 0};
    dir_tab[13] = '{ACT_DIR, 0, 0, 0, 0, 0, 0, 0, -16'sd32768, -16'sd32768, 0, 0};
    dir_tab[14] = '{ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'sd8388607, 0};
    dir_tab[15] = '{ACT_LOAD, 1, 1, 9, 65536, 65536, 0, 65536, 0, 0, 0, 0};
    dir_tab[16] = '{ACT_DIR, 0, 0, 0, 0, 0, 0, 0, -16'sd32768, 16'sd32767, 0, 0};
    dir_tab[17] = '{ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, -24'sd8388608, 0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (i = 0; i < 18; i++) send_beat(dir_tab[i]);
    drain();

    for (p = 0; p < 8; p++) begin
      cfg_write(REG_SPEAKER_COUNT, 16'(sc_tab[p]));
      cfg_write(REG_RAMP_STEP, 16'(rs_tab[p]));
      burst_in  = (p % 3 == 1);
      burst_out = (p % 4 == 2);
      for (n = 0; n < 25; n++) send_beat(random_beat());
      drain();
    end

    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
